// ===== hw/rtl/spp_pkg.sv =====
// Package for the segment perspective projector.
// Holds payload structs, camera register set, widths, constants and saturation.
// No dependencies.
package spp_pkg;

    localparam int IN_W   = 16;
    localparam int NUM_W  = 48;   // projection numerator, signed
    localparam int DEN_W  = 34;   // depth in 2^-14 units
    localparam int Q_W    = 17;   // quotient bits, MSB flags overflow
    localparam int LANE_LAT = 4 + Q_W + 1;

    localparam int DEF_SCREEN_WIDTH  = 640;
    localparam int DEF_SCREEN_HEIGHT = 480;

    localparam logic signed [9:0]  FOCAL_SCALE = 10'sd280;
    localparam int                 ROT_SHIFT   = 22;
    localparam int                 DZ_SHIFT    = 14;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_HEADING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_HEADING = 3'd4;

    localparam logic signed [15:0] RST_CAMERA_Z    = 16'sd640;
    localparam logic signed [15:0] RST_COS_HEADING = 16'sd16384;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] start_z;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] end_z;
    } t_seg_in;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] screen_start_x;
        logic signed [15:0] screen_start_y;
        logic signed [15:0] screen_end_x;
        logic signed [15:0] screen_end_y;
    } t_seg_out;

    typedef struct packed {
        logic signed [15:0] camera_x;
        logic signed [15:0] camera_y;
        logic signed [15:0] camera_z;
        logic signed [15:0] sin_heading;
        logic signed [15:0] cos_heading;
    } t_cam;

    // Clamp a sign/magnitude quotient to signed 16 bits.
    function automatic logic signed [15:0] sat_q(input logic [Q_W-1:0] q, input logic neg);
        logic [15:0] mag;
        logic signed [15:0] res;
        mag = q[15:0];
        if (q[Q_W-1]) begin
            res = neg ? 16'sh8000 : 16'sh7fff;
        end else if (!neg) begin
            res = mag[15] ? 16'sh7fff : $signed(mag);
        end else begin
            res = (mag > 16'h8000) ? 16'sh8000 : $signed(16'(~mag + 16'd1));
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/spp_divider.sv =====
// Pipelined restoring divider: signed numerator by positive denominator.
// One quotient bit per stage, truncation toward zero. Uses spp_pkg.
module spp_divider #(
    parameter int NUM_W = spp_pkg::NUM_W,
    parameter int DEN_W = spp_pkg::DEN_W,
    parameter int Q_W   = spp_pkg::Q_W
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    input  logic                    i_tag,
    output logic        [Q_W-1:0]   o_q,
    output logic                    o_neg,
    output logic                    o_tag
);
    localparam int REM_W = DEN_W + Q_W;

    logic [REM_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic             r_neg [Q_W];
    logic             r_tag [Q_W];

    logic [REM_W-1:0] w_mag;
    logic             w_neg;

    assign w_neg = i_num[NUM_W-1];
    assign w_mag = w_neg ? REM_W'(-i_num) : REM_W'(i_num);

    genvar g;
    generate
        for (g = 0; g < Q_W; g++) begin : g_stage
            logic [REM_W-1:0] rem_in, sub;
            logic [DEN_W-1:0] den_in;
            logic [Q_W-1:0]   q_in;
            logic             neg_in, tag_in, take;
            if (g == 0) begin : g_first
                assign rem_in = w_mag;
                assign den_in = i_den;
                assign q_in   = '0;
                assign neg_in = w_neg;
                assign tag_in = i_tag;
            end else begin : g_next
                assign rem_in = r_rem[g-1];
                assign den_in = r_den[g-1];
                assign q_in   = r_q[g-1];
                assign neg_in = r_neg[g-1];
                assign tag_in = r_tag[g-1];
            end
            assign sub  = REM_W'(den_in) << (Q_W - 1 - g);
            assign take = rem_in >= sub;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= take ? rem_in - sub : rem_in;
                    r_q[g]   <= {q_in[Q_W-2:0], take};
                    r_den[g] <= den_in;
                    r_neg[g] <= neg_in;
                    r_tag[g] <= tag_in;
                end
            end
        end
    endgenerate

    assign o_q   = r_q[Q_W-1];
    assign o_neg = r_neg[Q_W-1];
    assign o_tag = r_tag[Q_W-1];
endmodule

// ===== hw/rtl/spp_lane.sv =====
// One endpoint lane: offset, yaw rotation, near test, projection and division.
// Uses spp_pkg and spp_divider.
module spp_lane #(
    parameter int SCREEN_WIDTH  = spp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = spp_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  spp_pkg::t_cam        i_cam,
    input  logic signed [15:0]   i_px,
    input  logic signed [15:0]   i_py,
    input  logic signed [15:0]   i_pz,
    output logic                 o_near_ok,
    output logic signed [15:0]   o_sx,
    output logic signed [15:0]   o_sy
);
    localparam int NW = spp_pkg::NUM_W;
    localparam int DW = spp_pkg::DEN_W;
    localparam int HALF_W = SCREEN_WIDTH / 2;
    localparam int HALF_H = SCREEN_HEIGHT / 2;
    localparam logic signed [12:0] HALF_W_S = 13'(HALF_W);
    localparam logic signed [12:0] HALF_H_S = 13'(HALF_H);
    localparam logic signed [37:0] NEAR_LIMIT = 38'sd1 <<< spp_pkg::ROT_SHIFT;

    logic signed [16:0] r_x, r_y, r_dz1, r_dz2, r_dz3;
    logic signed [32:0] r_xc, r_ys, r_yc, r_xs;
    logic signed [33:0] r_across, r_depth;
    logic signed [NW-1:0] r_numx, r_numy;
    logic [DW-1:0] r_den;
    logic r_ok;

    logic signed [NW-1:0] n_numx, n_numy;
    logic signed [37:0]   d38, d14;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= 17'(i_px) + 17'(i_cam.camera_x);
            r_y   <= 17'(i_py) + 17'(i_cam.camera_y);
            r_dz1 <= 17'(i_pz) - 17'(i_cam.camera_z);
            r_xc  <= r_x * $signed(i_cam.cos_heading);
            r_ys  <= r_y * $signed(i_cam.sin_heading);
            r_yc  <= r_y * $signed(i_cam.cos_heading);
            r_xs  <= r_x * $signed(i_cam.sin_heading);
            r_dz2 <= r_dz1;
            r_across <= 34'(r_xc) + 34'(r_ys);
            r_depth  <= 34'(r_yc) - 34'(r_xs);
            r_dz3    <= r_dz2;
            r_numx <= n_numx;
            r_numy <= n_numy;
            r_den  <= DW'(r_depth);
            r_ok   <= d14 >= NEAR_LIMIT;
        end
    end

    always_comb begin
        d38 = 38'(r_depth);
        d14 = (d38 <<< 4) - (d38 <<< 1);
        n_numx = NW'(HALF_W_S) * NW'(r_depth) + NW'(spp_pkg::FOCAL_SCALE) * NW'(r_across);
        n_numy = NW'(HALF_H_S) * NW'(r_depth)
               - NW'(spp_pkg::FOCAL_SCALE) * (NW'(r_dz3) <<< spp_pkg::DZ_SHIFT);
    end

    logic [spp_pkg::Q_W-1:0] qx, qy;
    logic negx, negy, tagx, tagy;

    spp_divider u_div_x (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_numx), .i_den(r_den), .i_tag(r_ok),
        .o_q(qx), .o_neg(negx), .o_tag(tagx)
    );
    spp_divider u_div_y (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_numy), .i_den(r_den), .i_tag(r_ok),
        .o_q(qy), .o_neg(negy), .o_tag(tagy)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_near_ok <= tagx && tagy;
            o_sx      <= spp_pkg::sat_q(qx, negx);
            o_sy      <= spp_pkg::sat_q(qy, negy);
        end
    end
endmodule

// ===== hw/rtl/segment_perspective_projector.sv =====
// Top level of the segment perspective projector.
// Uses spp_pkg and spp_lane (which uses spp_divider).
//
// Takes one 3D segment per transfer and returns one projected result per
// segment, in order. Two lanes, one per endpoint, offset the point by the
// camera position, rotate it by the configured heading, check it against the
// near limit and divide the projection numerators by the depth in a
// 17-stage pipelined divider, one quotient bit per stage; a merge stage
// combines the near tests and zeroes the coordinates of an invisible
// segment. Throughput is one segment per cycle while results are accepted.
// The whole pipeline holds while a result waits unaccepted. Camera
// registers are written through the configuration port (always ready) and
// must only change while no segment is in flight.
module segment_perspective_projector #(
    parameter int SCREEN_WIDTH  = spp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = spp_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  spp_pkg::t_seg_in                   i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output spp_pkg::t_seg_out                  o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [spp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);
    localparam int LAT = spp_pkg::LANE_LAT;

    spp_pkg::t_cam     r_cam;
    logic [LAT-1:0]    r_vld;
    logic              r_out_valid;
    spp_pkg::t_seg_out r_out_data, n_out_data;
    logic              en;

    logic              ok0, ok1;
    logic signed [15:0] sx0, sy0, sx1, sy1;

    // Advance everything unless a finished result is being held.
    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Camera register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam.camera_x    <= '0;
            r_cam.camera_y    <= '0;
            r_cam.camera_z    <= spp_pkg::RST_CAMERA_Z;
            r_cam.sin_heading <= '0;
            r_cam.cos_heading <= spp_pkg::RST_COS_HEADING;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                spp_pkg::CFG_CAMERA_X:    r_cam.camera_x    <= $signed(i_cfg_data);
                spp_pkg::CFG_CAMERA_Y:    r_cam.camera_y    <= $signed(i_cfg_data);
                spp_pkg::CFG_CAMERA_Z:    r_cam.camera_z    <= $signed(i_cfg_data);
                spp_pkg::CFG_SIN_HEADING: r_cam.sin_heading <= $signed(i_cfg_data);
                spp_pkg::CFG_COS_HEADING: r_cam.cos_heading <= $signed(i_cfg_data);
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    spp_lane #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_lane_start (
        .i_clk(i_clk), .i_en(en), .i_cam(r_cam),
        .i_px(i_in_data.start_x), .i_py(i_in_data.start_y), .i_pz(i_in_data.start_z),
        .o_near_ok(ok0), .o_sx(sx0), .o_sy(sy0)
    );
    spp_lane #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_lane_end (
        .i_clk(i_clk), .i_en(en), .i_cam(r_cam),
        .i_px(i_in_data.end_x), .i_py(i_in_data.end_y), .i_pz(i_in_data.end_z),
        .o_near_ok(ok1), .o_sx(sx1), .o_sy(sy1)
    );

    // Merge: a segment is visible only if both endpoints pass.
    always_comb begin
        n_out_data = '0;
        n_out_data.visible = ok0 && ok1;
        if (ok0 && ok1) begin
            n_out_data.screen_start_x = sx0;
            n_out_data.screen_start_y = sy0;
            n_out_data.screen_end_x   = sx1;
            n_out_data.screen_end_y   = sy1;
        end
    end

    // Track which pipeline slots carry a segment.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[LAT-2:0], i_in_valid};
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
        end
    end

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted segment did not enter the pipeline");

    a_invisible_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.visible) |->
        (o_out_data.screen_start_x == 16'sd0 && o_out_data.screen_start_y == 16'sd0 &&
         o_out_data.screen_end_x == 16'sd0 && o_out_data.screen_end_y == 16'sd0))
        else $error("invisible segment carries nonzero coordinates");

    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_vld))
        else $error("pipeline moved while output was held");
endmodule

// ===== dv/tb_segment_perspective_projector.sv =====
// Testbench for the segment perspective projector: random and directed segments
// against a behavioral projection model, with random idling on both sides.
// Depends on spp_pkg and the segment_perspective_projector RTL.
module tb_segment_perspective_projector;

    localparam int LATENCY = 23;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    spp_pkg::t_seg_in in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    spp_pkg::t_seg_out out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [spp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Camera copy kept by the predictor.
    longint cam_x, cam_y, cam_z, sin_h, cos_h;

    spp_pkg::t_seg_in pending_segs[$];
    spp_pkg::t_seg_out expected_proj[$];
    int mismatch_count = 0;
    bit quiet_phase = 1'b0;   // no idling while set
    bit hold_input = 1'b0;    // sender pause requested by stimulus

    always #5 i_clk = ~i_clk;

    segment_perspective_projector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    // Project one endpoint; returns 0 when it lies inside the near limit.
    function automatic bit project_point(longint px, longint py, longint pz,
                                         output logic signed [15:0] sx,
                                         output logic signed [15:0] sy);
        longint x, y, across, depth, dz;
        x = px + cam_x;
        y = py + cam_y;
        across = x * cos_h + y * sin_h;
        depth = y * cos_h - x * sin_h;
        sx = '0;
        sy = '0;
        if (depth * 14 < (64'sd1 <<< 22)) return 1'b0;
        sx = clamp16((320 * depth + 280 * across) / depth);
        dz = (pz - cam_z) * 16384;
        sy = clamp16((240 * depth - 280 * dz) / depth);
        return 1'b1;
    endfunction

    function automatic spp_pkg::t_seg_out project_segment(spp_pkg::t_seg_in s);
        spp_pkg::t_seg_out r;
        logic signed [15:0] ax, ay, bx, by;
        bit ok;
        r = '0;
        ok = project_point(s.start_x, s.start_y, s.start_z, ax, ay);
        if (ok) ok = project_point(s.end_x, s.end_y, s.end_z, bx, by);
        if (ok) begin
            r.visible = 1'b1;
            r.screen_start_x = ax;
            r.screen_start_y = ay;
            r.screen_end_x = bx;
            r.screen_end_y = by;
        end
        return r;
    endfunction

    // Driver: present queued segments, idling at random.
    always @(posedge i_clk) begin
        if (in_valid && in_ready) begin
            expected_proj.push_back(project_segment(in_data));
        end
        if (!(in_valid && !in_ready)) begin
            if (i_rst_n && !hold_input && pending_segs.size() > 0
                    && (quiet_phase || $urandom_range(99) >= 29)) begin
                in_data <= pending_segs.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each transfer against the oldest prediction.
    always @(posedge i_clk) begin
        spp_pkg::t_seg_out exp_r;
        if (out_valid && out_ready) begin
            if (expected_proj.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", out_data);
            end else begin
                exp_r = expected_proj.pop_front();
                if (exp_r.visible !== out_data.visible
                        || exp_r.screen_start_x !== out_data.screen_start_x
                        || exp_r.screen_start_y !== out_data.screen_start_y
                        || exp_r.screen_end_x !== out_data.screen_end_x
                        || exp_r.screen_end_y !== out_data.screen_end_y) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h got %h", exp_r, out_data);
                end
            end
        end
        out_ready <= quiet_phase || ($urandom_range(99) >= 29);
    end

    // Drain: wait until every queued segment has come back.
    task automatic drain_pipeline();
        while (pending_segs.size() > 0 || in_valid || expected_proj.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [spp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            spp_pkg::CFG_CAMERA_X: cam_x = longint'($signed(val));
            spp_pkg::CFG_CAMERA_Y: cam_y = longint'($signed(val));
            spp_pkg::CFG_CAMERA_Z: cam_z = longint'($signed(val));
            spp_pkg::CFG_SIN_HEADING: sin_h = longint'($signed(val));
            spp_pkg::CFG_COS_HEADING: cos_h = longint'($signed(val));
            default: ;
        endcase
    endtask

    // Pick a coordinate: mostly near the camera so that depth passes often.
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed(16'($urandom_range(4095))) - 16'sd2048);
            default: return 16'($urandom_range(32767, 200));
        endcase
    endfunction

    function automatic spp_pkg::t_seg_in rand_segment();
        spp_pkg::t_seg_in s;
        s.start_x = rand_coord();
        s.start_y = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(30000, 100));
        s.start_z = rand_coord();
        s.end_x = rand_coord();
        s.end_y = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(30000, 100));
        s.end_z = rand_coord();
        return s;
    endfunction

    task automatic random_camera();
        int ang;
        ang = $urandom_range(7);
        write_reg(spp_pkg::CFG_CAMERA_X,
                  ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(512)));
        write_reg(spp_pkg::CFG_CAMERA_Y,
                  ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(512)));
        write_reg(spp_pkg::CFG_CAMERA_Z, 16'($urandom));
        case (ang)
            0: begin
                write_reg(spp_pkg::CFG_SIN_HEADING, 16'sd0);
                write_reg(spp_pkg::CFG_COS_HEADING, -16'sd16384);
            end
            1: begin
                write_reg(spp_pkg::CFG_SIN_HEADING, 16'sd16384);
                write_reg(spp_pkg::CFG_COS_HEADING, 16'sd0);
            end
            2: begin
                write_reg(spp_pkg::CFG_SIN_HEADING, -16'sd16384);
                write_reg(spp_pkg::CFG_COS_HEADING, 16'sd0);
            end
            3: begin
                write_reg(spp_pkg::CFG_SIN_HEADING, 16'sh8000);
                write_reg(spp_pkg::CFG_COS_HEADING, 16'sh7fff);
            end
            default: begin
                write_reg(spp_pkg::CFG_SIN_HEADING,
                          16'($signed(16'($urandom_range(32768))) - 16'sd16384));
                write_reg(spp_pkg::CFG_COS_HEADING, 16'($urandom_range(16384, 4000)));
            end
        endcase
    endtask

    initial begin
        spp_pkg::t_seg_in s;
        cam_x = 0; cam_y = 0; cam_z = 640; sin_h = 0; cos_h = 16384;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset camera, field extremes, near limit edges, saturation.
        pending_segs.push_back('{16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd512, 16'sd640});
        pending_segs.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
        pending_segs.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        pending_segs.push_back('{16'sd0, 16'sd19, 16'sd0, 16'sd0, 16'sd19, 16'sd0});
        pending_segs.push_back('{16'sd0, 16'sd18, 16'sd0, 16'sd0, 16'sd100, 16'sd0});
        pending_segs.push_back('{16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd18, 16'sd0});
        pending_segs.push_back('{16'sh7fff, 16'sd19, 16'sh8000, 16'sh8000, 16'sd19, 16'sh7fff});
        pending_segs.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        pending_segs.push_back('{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1});
        pending_segs.push_back('{16'sd1000, 16'sd256, -16'sd1000, -16'sd1000, 16'sd256, 16'sd1000});
        drain_pipeline();

        // Extreme camera settings.
        write_reg(spp_pkg::CFG_CAMERA_X, 16'sh8000);
        write_reg(spp_pkg::CFG_CAMERA_Y, 16'sh7fff);
        write_reg(spp_pkg::CFG_CAMERA_Z, 16'sh8000);
        write_reg(spp_pkg::CFG_SIN_HEADING, -16'sd16384);
        write_reg(spp_pkg::CFG_COS_HEADING, -16'sd16384);
        pending_segs.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        pending_segs.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        pending_segs.push_back('{16'sh8000, 16'sh7fff, 16'sh0, 16'sh7fff, 16'sh8000, 16'sh0});
        drain_pipeline();
        write_reg(spp_pkg::CFG_CAMERA_X, 16'sh7fff);
        write_reg(spp_pkg::CFG_CAMERA_Y, 16'sh8000);
        write_reg(spp_pkg::CFG_CAMERA_Z, 16'sh7fff);
        write_reg(spp_pkg::CFG_SIN_HEADING, 16'sd16384);
        write_reg(spp_pkg::CFG_COS_HEADING, 16'sd16384);
        pending_segs.push_back('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
        pending_segs.push_back('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0, 16'sh7fff, 16'sh7fff});
        drain_pipeline();

        // Random phases, each with a fresh camera.
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 0) begin
                write_reg(spp_pkg::CFG_CAMERA_X, 16'sd0);
                write_reg(spp_pkg::CFG_CAMERA_Y, 16'sd0);
                write_reg(spp_pkg::CFG_CAMERA_Z, 16'sd640);
                write_reg(spp_pkg::CFG_SIN_HEADING, 16'sd0);
                write_reg(spp_pkg::CFG_COS_HEADING, 16'sd16384);
            end else begin
                random_camera();
            end
            quiet_phase = (ph == 3);
            for (int k = 0; k < 140; k++) begin
                s = rand_segment();
                pending_segs.push_back(s);
                // Pause the sender once mid-phase until results catch up.
                if (ph == 5 && k == 70) begin
                    while (pending_segs.size() > 0 || in_valid) @(posedge i_clk);
                    hold_input = 1'b1;
                    while (expected_proj.size() > 0) @(posedge i_clk);
                    hold_input = 1'b0;
                end
            end
            drain_pipeline();
        end
        quiet_phase = 1'b0;

        if (mismatch_count == 0 && expected_proj.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== segment_perspective_projector.f =====
hw/rtl/spp_pkg.sv
hw/rtl/spp_divider.sv
hw/rtl/spp_lane.sv
hw/rtl/segment_perspective_projector.sv
dv/tb_segment_perspective_projector.sv
